// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; they compile to nothing under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold in the same cycle once the antecedent is true.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Property that must hold in the cycle after the antecedent is true.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_NOW(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/dtq_pkg.sv -----
// Shared types and constants for the delta timeout queue.
`default_nettype none

package dtq_pkg;

  // Fixed field widths of the item ports.
  localparam int DelayW  = 15;
  localparam int HandleW = 8;
  localparam int KindW   = 2;

  // Result kinds.
  typedef enum logic [KindW-1:0] {
    KIND_FIRED    = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_t;

  // Input commands.
  typedef enum logic {
    CMD_TICK     = 1'b0,
    CMD_SCHEDULE = 1'b1
  } command_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the input item
    logic insert;    // insert the latched schedule, emit an accepted result
    logic reject;    // emit a rejected result
    logic tick_dec;  // one tick passes on every entry while the head is not due
    logic pop;       // pop the head and emit a fired result
  } dtq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_sched;  // latched item is a schedule
    logic empty;     // no entries
    logic full;      // every slot used
    logic head_due;  // head entry has no remaining delay
    logic out_free;  // result register can take a new result this cycle
  } dtq_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dtq_ctrl.sv -----
// Controller state machine of the delta timeout queue.
`default_nettype none

module dtq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dtq_pkg::dtq_status_t  st,
  output dtq_pkg::dtq_cmd_t     cmd
);

  dtq_pkg::state_t state;
  dtq_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      dtq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = dtq_pkg::ST_EXEC;
        end
      end
      dtq_pkg::ST_EXEC: begin
        if (st.is_sched) begin
          // A schedule always gives one result, so wait for a free result slot.
          if (st.out_free) begin
            cmd.insert = !st.full;
            cmd.reject = st.full;
            state_next = dtq_pkg::ST_IDLE;
          end
        end else if (st.empty) begin
          state_next = dtq_pkg::ST_IDLE;
        end else begin
          cmd.tick_dec = 1'b1;
          state_next   = dtq_pkg::ST_POP;
        end
      end
      dtq_pkg::ST_POP: begin
        // Pop due entries one per cycle while the result slot accepts them.
        if (st.head_due) begin
          cmd.pop = st.out_free;
        end else begin
          state_next = dtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dtq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dtq_datapath.sv -----
// Datapath of the delta timeout queue: sorted entry cells and the result register.
`default_nettype none

module dtq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DELAY_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dtq_pkg::dtq_cmd_t             cmd,
  output dtq_pkg::dtq_status_t          st,
  input  logic                          command,
  input  logic [dtq_pkg::DelayW-1:0]    delay,
  input  logic [dtq_pkg::HandleW-1:0]   handle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dtq_pkg::KindW-1:0]     kind,
  output logic [dtq_pkg::HandleW-1:0]   fired_handle,
  output logic                          last
);

  // Remaining delays never exceed the masked input delay.
  localparam int RemW = (DELAY_BITS < dtq_pkg::DelayW) ? DELAY_BITS : dtq_pkg::DelayW;
  localparam int CntW = $clog2(DEPTH + 1);

  // Each cell holds the absolute remaining delay of one entry, head first.
  // The list stays sorted, so the running delta sum equals the cell value.
  logic [RemW-1:0]             rem      [DEPTH];
  logic [RemW-1:0]             rem_next [DEPTH];
  logic [dtq_pkg::HandleW-1:0] hnd      [DEPTH];
  logic [dtq_pkg::HandleW-1:0] hnd_next [DEPTH];
  logic [CntW-1:0]             count;
  logic [CntW-1:0]             count_next;

  // Latched input item.
  dtq_pkg::command_t           cmd_r;
  logic [RemW-1:0]             dly_r;
  logic [dtq_pkg::HandleW-1:0] hdl_r;

  // Result register.
  dtq_pkg::kind_t              out_kind;
  logic [dtq_pkg::HandleW-1:0] out_handle;
  logic                        out_last;

  logic [DEPTH-1:0] gt;
  logic [DEPTH-1:0] gt_prev;
  logic             emit;

  // Per-cell compare: the cell lies past the insertion point.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CntW'(i) >= count) || (rem[i] > dly_r);
    end
  end
  assign gt_prev = {gt[DEPTH-2:0], 1'b0};

  // Cell update: insert with shift up, tick on the head, or pop with shift down.
  always_comb begin
    rem_next   = rem;
    hnd_next   = hnd;
    count_next = count;
    if (cmd.insert) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (gt[i]) begin
          if (gt_prev[i]) begin
            rem_next[i] = (i > 0) ? rem[(i > 0) ? i - 1 : 0] : rem[i];
            hnd_next[i] = (i > 0) ? hnd[(i > 0) ? i - 1 : 0] : hnd[i];
          end else begin
            rem_next[i] = dly_r;
            hnd_next[i] = hdl_r;
          end
        end
      end
      count_next = count + 1'b1;
    end else if (cmd.tick_dec) begin
      // A tick only passes when the head still has time left.
      if (rem[0] != '0) begin
        for (int i = 0; i < DEPTH; i++) begin
          rem_next[i] = rem[i] - 1'b1;
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        rem_next[i] = rem[i+1];
        hnd_next[i] = hnd[i+1];
      end
      count_next = count - 1'b1;
    end
  end

  // Entry cells hold payload only.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      rem[i] <= rem_next[i];
      hnd[i] <= hnd_next[i];
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Input item capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= dtq_pkg::command_t'(command);
      dly_r <= delay[RemW-1:0];
      hdl_r <= handle;
    end
  end

  assign emit = cmd.insert || cmd.reject || cmd.pop;

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; a fired entry is last unless the next entry is also due.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      out_kind   <= dtq_pkg::KIND_ACCEPTED;
      out_handle <= hdl_r;
      out_last   <= 1'b1;
    end else if (cmd.reject) begin
      out_kind   <= dtq_pkg::KIND_REJECTED;
      out_handle <= hdl_r;
      out_last   <= 1'b1;
    end else if (cmd.pop) begin
      out_kind   <= dtq_pkg::KIND_FIRED;
      out_handle <= hnd[0];
      out_last   <= !((count > CntW'(1)) && (rem[1] == '0));
    end
  end

  assign kind         = out_kind;
  assign fired_handle = out_handle;
  assign last         = out_last;

  // Status toward the controller.
  assign st.is_sched = (cmd_r == dtq_pkg::CMD_SCHEDULE);
  assign st.empty    = (count == '0);
  assign st.full     = (count == CntW'(DEPTH));
  assign st.head_due = (count != '0) && (rem[0] == '0);
  assign st.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/delta_timeout_queue.sv -----
// Top level of the delta timeout queue: controller, datapath and checks.
`default_nettype none

// One-shot timeout queue. A schedule item (command 1) places a handle in a
// list kept sorted by remaining delay, behind every entry due no later, and
// gives one result: accepted, or rejected when all DEPTH slots are in use.
// A tick item (command 0) takes one tick off the queue unless the head is
// already due, then fires every due entry head first, one result each, with
// last marking the final one; a tick on an empty queue or with nothing due
// gives no result. Delays are taken to the low DELAY_BITS bits (at most 15).
// One item is handled at a time: a schedule passes from ST_IDLE through ST_EXEC
// and back to ST_IDLE before the next item can be accepted, as does a tick on
// an empty queue; otherwise a tick goes on from ST_EXEC to ST_POP, which pops
// one due entry per cycle while the result register is free, set by the single
// result register and the one-pop-per-cycle shift of the entry cells. Output
// stalls hold ST_EXEC and ST_POP; a new item may be accepted while the last result is still waiting.
module delta_timeout_queue #(
  parameter int DEPTH      = 16,
  parameter int DELAY_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [dtq_pkg::DelayW-1:0]    delay,
  input  logic [dtq_pkg::HandleW-1:0]   handle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dtq_pkg::KindW-1:0]     kind,
  output logic [dtq_pkg::HandleW-1:0]   fired_handle,
  output logic                          last
);

  dtq_pkg::dtq_cmd_t    cmd;
  dtq_pkg::dtq_status_t st;

  // Sequencing of each item.
  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Entry cells and result register.
  dtq_datapath #(
    .DEPTH      (DEPTH),
    .DELAY_BITS (DELAY_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .command      (command),
    .delay        (delay),
    .handle       (handle),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .fired_handle (fired_handle),
    .last         (last)
  );

`include "assert_macros.svh"

  // Only one item is in work at a time.
  `ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)

  // A result is only produced when the result register can take it.
  `ASSERT_NOW(a_emit_free, clk, rst, cmd.pop || cmd.insert || cmd.reject, st.out_free)

  // Schedule results are always the last result of their item.
  `ASSERT_NOW(a_sched_last, clk, rst, out_valid && (kind != dtq_pkg::KIND_FIRED), last)

  // An insert never happens on a full queue.
  `ASSERT_NOW(a_no_overfill, clk, rst, cmd.insert, !st.full)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the delta timeout queue: directed cases, then random traffic.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dtq_pkg::*;

  localparam int QueueDepth  = 16;
  localparam int CycleLimit  = 300000;
  localparam int SettleCycles = 24;

  // Idling modes for the two channels.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One expected result item.
  typedef struct packed {
    kind_t              kind;
    logic [HandleW-1:0] handle;
    logic               last;
  } timeout_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               command = 1'b0;
  logic [DelayW-1:0]  delay = '0;
  logic [HandleW-1:0] handle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [KindW-1:0]   kind;
  logic [HandleW-1:0] fired_handle;
  logic               last;

  // Shadow copy of the delta list.
  logic [DelayW-1:0]  list_delta [QueueDepth];
  logic [HandleW-1:0] list_handle[QueueDepth];
  int                 list_count;

  timeout_result_t    pending_results[$];
  timeout_result_t    oldest;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int error_count     = 0;
  int cycle_count     = 0;
  int items_sent      = 0;
  int fired_seen      = 0;
  int accepted_seen   = 0;
  int rejected_seen   = 0;

  delta_timeout_queue dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .delay       (delay),
    .handle      (handle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .fired_handle(fired_handle),
    .last        (last)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("[delta_timeout_queue] ERROR");
      $finish;
    end
  end

  // Append one expected result at the tail of the pending list.
  function automatic void expect_result(timeout_result_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  // Apply one accepted item to the shadow list and queue up the results it causes.
  function automatic void apply_to_timer_list(command_t cmd, logic [DelayW-1:0] dly,
                                              logic [HandleW-1:0] hdl);
    int              sum;
    int              prev;
    int              pos;
    int              n_fired;
    timeout_result_t res;
    timeout_result_t fired[QueueDepth];
    sum = 0;
    n_fired = 0;
    if (cmd == CMD_SCHEDULE) begin
      if (list_count >= QueueDepth) begin
        res = '{kind: KIND_REJECTED, handle: hdl, last: 1'b1};
        expect_result(res);
        return;
      end
      // Find the first entry whose running sum exceeds the delay.
      pos = list_count;
      for (int i = 0; i < list_count; i++) begin
        prev = sum;
        sum = sum + int'(list_delta[i]);
        if (sum > int'(dly)) begin
          pos = i;
          list_delta[i] = DelayW'(sum - int'(dly));
          sum = prev;
          break;
        end
      end
      for (int i = list_count; i > pos; i--) begin
        list_delta[i]  = list_delta[i-1];
        list_handle[i] = list_handle[i-1];
      end
      list_delta[pos]  = DelayW'(int'(dly) - sum);
      list_handle[pos] = hdl;
      list_count++;
      res = '{kind: KIND_ACCEPTED, handle: hdl, last: 1'b1};
      expect_result(res);
      return;
    end
    // A tick on an empty queue does nothing.
    if (list_count == 0) return;
    if (list_delta[0] != '0) list_delta[0] = list_delta[0] - 1'b1;
    // Pop every leading entry that is due.
    while (list_count > 0 && list_delta[0] == '0) begin
      fired[n_fired] = '{kind: KIND_FIRED, handle: list_handle[0], last: 1'b0};
      n_fired++;
      for (int i = 1; i < list_count; i++) begin
        list_delta[i-1]  = list_delta[i];
        list_handle[i-1] = list_handle[i];
      end
      list_count--;
    end
    for (int i = 0; i < n_fired; i++) begin
      res = fired[i];
      res.last = (i == n_fired - 1);
      expect_result(res);
    end
  endfunction

  // Receiver: random stalls and the result check.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: kind %0d handle %0d last %0d",
                 kind, fired_handle, last);
          error_count++;
        end else begin
          oldest = pending_results[0];
          pending_results.delete(0);
          if (kind != oldest.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", oldest.kind, kind);
            error_count++;
          end
          if (fired_handle != oldest.handle) begin
            $error("fired_handle mismatch: expected %0d, actual %0d", oldest.handle,
                   fired_handle);
            error_count++;
          end
          if (last != oldest.last) begin
            $error("last mismatch: expected %0d, actual %0d", oldest.last, last);
            error_count++;
          end
          case (oldest.kind)
            KIND_FIRED:    fired_seen++;
            KIND_ACCEPTED: accepted_seen++;
            default:       rejected_seen++;
          endcase
        end
      end
    end
  end

  task automatic set_idle_mode(idle_mode_t mode);
    sender_idle_pct = (mode == IDLE_SENDER) ? 72 : (mode == IDLE_BOTH) ? 23 : 0;
    recv_stall_pct  = (mode == IDLE_RECEIVER) ? 72 : (mode == IDLE_BOTH) ? 23 : 0;
  endtask

  // Send one item; returns at the edge where it was accepted, with valid still high.
  task automatic send_item(command_t cmd, logic [DelayW-1:0] dly, logic [HandleW-1:0] hdl);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    delay    <= dly;
    handle   <= hdl;
    do @(posedge clk); while (!in_ready);
    apply_to_timer_list(cmd, dly, hdl);
    items_sent++;
  endtask

  // Hold off the sender until every expected result has arrived, then let the block settle.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // A tick on an empty queue gives nothing.
  task automatic test_empty_tick();
    send_item(CMD_TICK, '0, 8'h00);
    wait_results_drained();
  endtask

  // Zero-delay entries queue behind each other and fire on the next tick.
  task automatic test_zero_delay();
    send_item(CMD_SCHEDULE, '0, 8'h01);
    send_item(CMD_SCHEDULE, '0, 8'h02);
    send_item(CMD_TICK, '0, 8'h00);
    wait_results_drained();
  endtask

  // Fill every slot, get one rejection, then fire the whole queue on one tick.
  task automatic test_full_queue();
    while (list_count < QueueDepth)
      send_item(CMD_SCHEDULE, DelayW'(1), HandleW'(8'h10 + list_count));
    send_item(CMD_SCHEDULE, DelayW'(1), 8'hEE);
    send_item(CMD_TICK, '0, 8'h00);
    wait_results_drained();
  endtask

  // Largest delay with the largest handle, then a tick with nothing due.
  task automatic test_extremes();
    send_item(CMD_SCHEDULE, {DelayW{1'b1}}, {HandleW{1'b1}});
    send_item(CMD_TICK, {DelayW{1'b1}}, {HandleW{1'b1}});
    wait_results_drained();
  endtask

  // Bursts of schedules and ticks with random content under one idling mode.
  task automatic test_random_traffic(int n_items, idle_mode_t mode, bit pause_midway);
    int                 sent;
    int                 burst_len;
    int                 sched_pct;
    int                 pick;
    logic [DelayW-1:0]  dly;
    command_t           cmd;
    sent = 0;
    set_idle_mode(mode);
    while (sent < n_items) begin
      burst_len = $urandom_range(1, 8);
      sched_pct = ($urandom_range(1) == 1) ? 80 : 25;
      for (int k = 0; k < burst_len && sent < n_items; k++) begin
        cmd  = ($urandom_range(99) < sched_pct) ? CMD_SCHEDULE : CMD_TICK;
        pick = $urandom_range(99);
        if (pick < 85) dly = DelayW'($urandom_range(0, 6));
        else if (pick < 97) dly = DelayW'($urandom_range(0, 40));
        else dly = DelayW'($urandom);
        send_item(cmd, dly, HandleW'($urandom));
        sent++;
        if (pause_midway && sent == n_items / 2) wait_results_drained();
      end
    end
    wait_results_drained();
  endtask

  initial begin
    for (int i = 0; i < QueueDepth; i++) begin
      list_delta[i]  = '0;
      list_handle[i] = '0;
    end
    list_count = 0;
    set_idle_mode(IDLE_NONE);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_tick();
    test_zero_delay();
    test_full_queue();
    test_extremes();

    test_random_traffic(22, IDLE_NONE, 1'b0);
    test_random_traffic(22, IDLE_SENDER, 1'b1);
    test_random_traffic(22, IDLE_RECEIVER, 1'b0);
    test_random_traffic(22, IDLE_BOTH, 1'b1);

    $display("covered %0d input items over four idling modes in %0d cycles", items_sent,
             cycle_count);
    $display("results checked: %0d fired, %0d accepted, %0d rejected, %0d errors",
             fired_seen, accepted_seen, rejected_seen, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[delta_timeout_queue] OK");
    end else begin
      $display("[delta_timeout_queue] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
